FILE: rtl/core/kfr_pkg.sv
package kfr_pkg;

  localparam int GA_W  = 18;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_LEVEL_MODE   = 2'd0,
    REG_SINGLE_LEVEL = 2'd1,
    REG_WIDE_ROW     = 2'd2,
    REG_ROM_IS_LARGE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LVL_PORT  = 2'd0,
    LVL_WRITE = 2'd1,
    LVL_LOCK  = 2'd2
  } lvl_mode_t;

  localparam logic [GA_W-1:0] ROW_KEEP  = 18'h3f800;
  localparam logic [GA_W-1:0] COL_KEEP  = 18'h007e0;
  localparam logic [GA_W:0]   SMALL_ROM = 19'h20000;
  localparam logic [GA_W:0]   LARGE_ROM = 19'h40000;
  localparam logic [7:0]      BYTE_NONE = 8'hff;

  typedef struct packed {
    logic            is_fetch;
    logic            ok;
    logic            in_range;
    logic [GA_W-1:0] addr;
  } rd_req_t;

endpackage

FILE: rtl/core/kfr_in_if.sv
interface kfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  port_select;
  logic [7:0]  data_byte;
  logic [17:0] load_address;

  modport source (output valid, operation, port_select, data_byte, load_address,
                  input ready);
  modport sink (input valid, operation, port_select, data_byte, load_address,
                output ready);
endinterface

FILE: rtl/core/kfr_out_if.sv
interface kfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_accepted;

  modport source (output valid, read_byte, read_accepted, input ready);
  modport sink (input valid, read_byte, read_accepted, output ready);
endinterface

FILE: rtl/core/kfr_glyph_ctrl.sv
module kfr_glyph_ctrl #(
  parameter int ROM_BYTES = 262144
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kfr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kfr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_fire,
  input  logic [1:0]                 operation,
  input  logic [1:0]                 port_select,
  input  logic [7:0]                 data_byte,
  output kfr_pkg::rd_req_t           req
);

  localparam logic [kfr_pkg::GA_W:0] LIM_BYTES = (kfr_pkg::GA_W+1)'(ROM_BYTES);

  logic [1:0]              level_mode_r;
  logic                    single_level_r;
  logic                    wide_row_r;
  logic                    rom_is_large_r;
  logic [kfr_pkg::GA_W-1:0] ga_r, ga_nxt;
  logic                    wl_r, wl_nxt;

  logic [1:0]              port;
  logic                    level;
  logic [6:0]              row;
  logic [kfr_pkg::GA_W:0]  size;
  logic [kfr_pkg::GA_W:0]  lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_mode_r   <= 2'd0;
      single_level_r <= 1'b0;
      wide_row_r     <= 1'b0;
      rom_is_large_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kfr_pkg::REG_LEVEL_MODE:   level_mode_r   <= cfg_wdata;
        kfr_pkg::REG_SINGLE_LEVEL: single_level_r <= cfg_wdata[0];
        kfr_pkg::REG_WIDE_ROW:     wide_row_r     <= cfg_wdata[0];
        kfr_pkg::REG_ROM_IS_LARGE: rom_is_large_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    port = {port_select[1] & ~single_level_r, port_select[0]};
    req.ok = 1'b1;
    case (level_mode_r)
      kfr_pkg::LVL_LOCK: begin
        level  = wl_r;
        req.ok = (port[1] == wl_r);
      end
      kfr_pkg::LVL_WRITE: level = wl_r;
      default:            level = port[1];
    endcase
    req.is_fetch = (operation == kfr_pkg::OP_READ) || (operation == kfr_pkg::OP_PEEK);
    req.addr     = {ga_r[kfr_pkg::GA_W-1] | level, ga_r[kfr_pkg::GA_W-2:0]};
    size         = rom_is_large_r ? kfr_pkg::LARGE_ROM : kfr_pkg::SMALL_ROM;
    lim          = (size > LIM_BYTES) ? LIM_BYTES : size;
    req.in_range = ({1'b0, req.addr} < lim);
    row          = wide_row_r ? data_byte[6:0] : {1'b0, data_byte[5:0]};

    ga_nxt = ga_r;
    wl_nxt = wl_r;
    if (in_fire) begin
      case (operation)
        kfr_pkg::OP_WRITE: begin
          wl_nxt = port[1];
          if (port[0]) begin
            ga_nxt = (ga_r & kfr_pkg::COL_KEEP) | {row, 11'b0};
          end else begin
            ga_nxt = (ga_r & kfr_pkg::ROW_KEEP) | {7'b0, data_byte[5:0], 5'b0};
          end
        end
        kfr_pkg::OP_READ: begin
          if (req.ok) begin
            ga_nxt = {ga_r[kfr_pkg::GA_W-1:5], ga_r[4:0] + 5'd1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ga_r <= '0;
      wl_r <= 1'b0;
    end else begin
      ga_r <= ga_nxt;
      wl_r <= wl_nxt;
    end
  end

endmodule

FILE: rtl/core/kanji_font_rom_port_unit.sv
// Font ROM reader behind a small set of I/O ports.
// The input channel carries port writes, port reads, peeks and font loads;
// each input transfer yields exactly one transfer on the result channel.
// Column and row writes set the glyph address; a read returns the font byte
// and, when accepted, advances the low five address bits; a peek returns it without moving.
// Loads fill the internal font memory one byte at a time; a byte that was
// never loaded reads as an unknown value.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must
// write it only while no work is in flight, which the block does not enforce.
// A result passes first through the synchronous font memory read, then
// through the output register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the output register and the memory stage hold
// up to two items; input ready drops only when both are full.
// Reset clears the glyph address, the write level, the configuration
// registers (ROM size defaults to large) and the pipeline valid bits; the
// font memory keeps its contents.
module kanji_font_rom_port_unit #(
  parameter int ROM_BYTES = 262144
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kfr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kfr_pkg::CFG_DW-1:0] cfg_wdata,
  kfr_in_if.sink                     in_ch,
  kfr_out_if.source                  out_ch
);

  localparam int AW = $clog2(ROM_BYTES);
  localparam logic [kfr_pkg::GA_W:0] LIM_BYTES = (kfr_pkg::GA_W+1)'(ROM_BYTES);

  kfr_pkg::rd_req_t req;

  logic [7:0] font_mem [ROM_BYTES];
  logic [7:0] rd_data_r;

  logic       in_fire;
  logic       rd_en;
  logic       wr_en;
  logic       s1_move;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_fetch_r, s1_ok_r, s1_range_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_acc_r;

  kfr_glyph_ctrl #(
    .ROM_BYTES (ROM_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .operation   (in_ch.operation),
    .port_select (in_ch.port_select),
    .data_byte   (in_ch.data_byte),
    .req         (req)
  );

  assign s1_move     = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_move;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign rd_en       = in_fire & req.is_fetch & req.ok & req.in_range;
  assign wr_en       = in_fire & (in_ch.operation == kfr_pkg::OP_LOAD) &
                       ({1'b0, in_ch.load_address} < LIM_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[in_ch.load_address[AW-1:0]] <= in_ch.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= font_mem[req.addr[AW-1:0]];
    end
  end

  assign s1_valid_nxt  = in_fire | (s1_valid_r & ~s1_move);
  assign out_valid_nxt = s1_move | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_fetch_r <= req.is_fetch;
      s1_ok_r    <= req.is_fetch & req.ok;
      s1_range_r <= req.in_range;
    end
    if (s1_move) begin
      if (!s1_fetch_r) begin
        out_byte_r <= 8'h00;
      end else if (!s1_ok_r || !s1_range_r) begin
        out_byte_r <= kfr_pkg::BYTE_NONE;
      end else begin
        out_byte_r <= rd_data_r;
      end
      out_acc_r <= s1_ok_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_byte     = out_byte_r;
  assign out_ch.read_accepted = out_acc_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || s1_move))
    else $error("input transfer while the memory stage is stalled");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (s1_valid_r && s1_fetch_r && s1_ok_r && s1_range_r))
    else $error("memory read data without a matching fetch in stage one");

  a_ok_only_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fetch_r) |-> !s1_ok_r)
    else $error("write or load marked as an accepted read");

endmodule
